// ===== sv/gwt_pkg.sv =====
// gwt_pkg: widths, format codes and result types of the glow wave texel generator
// no dependencies; imported by the coordinate and texel interfaces and every module of the block

package gwt_pkg;

	localparam int COORD_W = 7;
	localparam int FRAC_W  = 7;
	localparam int SQ_W    = 13;
	localparam int SLOPE_W = 9;
	localparam int PROD_W  = SQ_W + SLOPE_W;
	localparam int WAVE_W  = 20;
	localparam int BYTE_W  = 8;
	localparam int USED_W  = 3;

	localparam logic [COORD_W-1:0] HALF_PERIOD = 7'd32;
	localparam logic [COORD_W-1:0] WAVE_END    = 7'd95;
	localparam logic [COORD_W-1:0] WAVE_START  = 7'd96;
	localparam logic [SLOPE_W-1:0] SLOPE_BASE  = 9'd384;
	localparam logic signed [WAVE_W:0] WAVE_ONE = 21'sd262144;

	localparam logic [USED_W-1:0] BYTES_SIGNED = 3'd2;
	localparam logic [USED_W-1:0] BYTES_FOUR   = 3'd4;
	localparam logic [BYTE_W-1:0] SIGNED_MAX   = 8'h7f;
	localparam logic [BYTE_W-1:0] SIGNED_MIN   = 8'h80;
	localparam logic [BYTE_W-1:0] UNSIGNED_TOP = 8'h7f;

	typedef enum logic {
		FMT_SIGNED    = 1'b0,
		FMT_FOUR_BYTE = 1'b1
	} gwt_format_t;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} gwt_stage_en_t;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_zero;
		logic [BYTE_W-1:0] byte_one;
		logic [BYTE_W-1:0] byte_two;
		logic [BYTE_W-1:0] byte_three;
		logic [USED_W-1:0] bytes_used;
	} gwt_texel_t;

endpackage

// ===== sv/gwt_if.sv =====
// gwt channel interfaces: coordinate input, texel output, format write
// depends on gwt_pkg for field widths

interface gwt_coord_if;
	import gwt_pkg::*;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] column;
	logic [COORD_W-1:0] row;
	modport source (output valid, output column, output row, input ready);
	modport sink (input valid, input column, input row, output ready);
	modport mon (input valid, input column, input row, input ready);
endinterface

interface gwt_texel_if;
	import gwt_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] byte_zero;
	logic [BYTE_W-1:0] byte_one;
	logic [BYTE_W-1:0] byte_two;
	logic [BYTE_W-1:0] byte_three;
	logic [USED_W-1:0] bytes_used;
	modport source (output valid, output byte_zero, output byte_one, output byte_two,
		output byte_three, output bytes_used, input ready);
	modport sink (input valid, input byte_zero, input byte_one, input byte_two,
		input byte_three, input bytes_used, output ready);
	modport mon (input valid, input byte_zero, input byte_one, input byte_two,
		input byte_three, input bytes_used, input ready);
endinterface

interface gwt_cfg_if;
	logic       valid;
	logic       ready;
	logic [0:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
	modport mon (input valid, input data, input ready);
endinterface

// ===== sv/gwt_wave_lane.sv =====
// gwt_wave_lane: three-stage wave datapath for one coordinate, phase fold, square, cubic
// depends on gwt_pkg; stage enables come from the top level's pipeline control

module gwt_wave_lane (
	input  logic                            clk,
	input  gwt_pkg::gwt_stage_en_t          en,
	input  logic [gwt_pkg::COORD_W-1:0]     coord,
	output logic signed [gwt_pkg::WAVE_W-1:0] wave
);
	import gwt_pkg::*;

	logic [FRAC_W-1:0]  frac_d;
	logic               odd_d;
	logic [FRAC_W-1:0]  frac_s1;
	logic               odd_s1;
	logic [SQ_W-1:0]    sq_s2;
	logic [SLOPE_W-1:0] slope_s2;
	logic               odd_s2;
	logic [PROD_W-1:0]  prod;
	logic signed [WAVE_W:0] base;
	logic signed [WAVE_W:0] signed_wave;
	logic signed [WAVE_W-1:0] wave_s3;
	logic [2*FRAC_W-1:0] sq_full;

	// fold the phase into fraction and parity of the integral part
	always_comb begin
		if (coord <= HALF_PERIOD) begin
			frac_d = coord + HALF_PERIOD;
			odd_d  = 1'b1;
		end else if (coord <= WAVE_END) begin
			frac_d = coord - HALF_PERIOD;
			odd_d  = 1'b0;
		end else begin
			frac_d = coord - WAVE_START;
			odd_d  = 1'b1;
		end
	end

	assign sq_full = frac_s1 * frac_s1;
	assign prod    = sq_s2 * slope_s2;
	assign base    = WAVE_ONE - $signed({1'b0, prod[WAVE_W-1:0]});
	assign signed_wave = odd_s2 ? -base : base;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			frac_s1 <= frac_d;
			odd_s1  <= odd_d;
		end
		if (en.s2) begin
			sq_s2    <= sq_full[SQ_W-1:0];
			slope_s2 <= SLOPE_BASE - {frac_s1, 2'b00};
			odd_s2   <= odd_s1;
		end
		if (en.s3) begin
			wave_s3 <= signed_wave[WAVE_W-1:0];
		end
	end

	assign wave = wave_s3;

endmodule

// ===== sv/gwt_encoder.sv =====
// gwt_encoder: turns the two wave values into texel bytes for the selected format
// depends on gwt_pkg for widths, format codes and the texel type

module gwt_encoder (
	input  logic signed [gwt_pkg::WAVE_W-1:0] wave_x,
	input  logic signed [gwt_pkg::WAVE_W-1:0] wave_y,
	input  gwt_pkg::gwt_format_t              format,
	output gwt_pkg::gwt_texel_t               texel
);
	import gwt_pkg::*;

	function automatic logic [BYTE_W-1:0] enc_signed(input logic signed [WAVE_W-1:0] v);
		logic signed [BYTE_W:0] q;
		q = v[WAVE_W-1:11];
		if (v[WAVE_W-1] && (v[10:0] != 11'd0)) begin
			q = q + 9'sd1;
		end
		if (q > 9'sd127) begin
			return SIGNED_MAX;
		end
		if (q < -9'sd128) begin
			return SIGNED_MIN;
		end
		return q[BYTE_W-1:0];
	endfunction

	function automatic logic [BYTE_W-1:0] enc_unsigned(input logic signed [WAVE_W-1:0] v);
		logic signed [WAVE_W:0] num;
		logic [WAVE_W+7:0] scaled;
		logic [BYTE_W:0]   s;
		num    = {v[WAVE_W-1], v} + WAVE_ONE;
		scaled = {num[WAVE_W-1:0], 8'd0} - {8'd0, num[WAVE_W-1:0]};
		s      = scaled[WAVE_W+7:WAVE_W-1];
		if (num < 0) begin
			return 8'd0;
		end
		if (s >= 9'd255) begin
			return UNSIGNED_TOP;
		end
		return s[BYTE_W-1:0];
	endfunction

	always_comb begin
		texel.byte_three = 8'd0;
		case (format)
			FMT_SIGNED: begin
				texel.byte_zero  = enc_signed(wave_x);
				texel.byte_one   = enc_signed(wave_y);
				texel.byte_two   = 8'd0;
				texel.bytes_used = BYTES_SIGNED;
			end
			FMT_FOUR_BYTE: begin
				texel.byte_zero  = 8'd0;
				texel.byte_one   = enc_unsigned(wave_y);
				texel.byte_two   = enc_unsigned(wave_x);
				texel.bytes_used = BYTES_FOUR;
			end
			default: begin
				texel.byte_zero  = 8'd0;
				texel.byte_one   = 8'd0;
				texel.byte_two   = 8'd0;
				texel.bytes_used = BYTES_SIGNED;
			end
		endcase
	end

endmodule

// ===== sv/glow_wave_texel_generator.sv =====
// glow_wave_texel_generator: one texel per cycle while the output is taken; each accepted word
// passes stages s1 to s4 to a valid result; one word accepted every cycle while the output is taken
// stages: phase fold, square and slope, cubic wave, encode into the output register
// a stall at the output holds every stage in place; bubbles close up behind it
// reset (arst_n, asynchronous) clears all valid bits and sets format_q to signed
// depends on gwt_pkg, gwt_if, gwt_wave_lane, gwt_encoder

module glow_wave_texel_generator (
	input  logic           clk,
	input  logic           arst_n,
	gwt_coord_if.sink      coord,
	gwt_texel_if.source    texel,
	gwt_cfg_if.sink        cfg
);
	import gwt_pkg::*;

	gwt_format_t   format_q;
	logic          vld_s1, vld_s2, vld_s3, vld_s4;
	logic          rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	gwt_stage_en_t en;
	logic signed [WAVE_W-1:0] wave_x, wave_y;
	gwt_texel_t    texel_d;
	gwt_texel_t    texel_s4;

	assign rdy_s4 = !vld_s4 || texel.ready;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign en.s1 = rdy_s1;
	assign en.s2 = rdy_s2;
	assign en.s3 = rdy_s3;

	assign coord.ready = rdy_s1;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_q <= FMT_SIGNED;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
		end else begin
			if (cfg.valid) begin
				format_q <= gwt_format_t'(cfg.data[0]);
			end
			if (rdy_s1) vld_s1 <= coord.valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	gwt_wave_lane u_lane_x (
		.clk   (clk),
		.en    (en),
		.coord (coord.column),
		.wave  (wave_x)
	);

	gwt_wave_lane u_lane_y (
		.clk   (clk),
		.en    (en),
		.coord (coord.row),
		.wave  (wave_y)
	);

	gwt_encoder u_enc (
		.wave_x (wave_x),
		.wave_y (wave_y),
		.format (format_q),
		.texel  (texel_d)
	);

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			texel_s4 <= texel_d;
		end
	end

	assign texel.valid      = vld_s4;
	assign texel.byte_zero  = texel_s4.byte_zero;
	assign texel.byte_one   = texel_s4.byte_one;
	assign texel.byte_two   = texel_s4.byte_two;
	assign texel.byte_three = texel_s4.byte_three;
	assign texel.bytes_used = texel_s4.bytes_used;

endmodule

// ===== sv/gwt_checker.sv =====
// gwt_checker: port-level checks on the texel output of glow_wave_texel_generator
// depends on gwt_pkg; attached to the top level's texel channel by the bind below

module gwt_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         valid,
	input logic                         ready,
	input logic [gwt_pkg::BYTE_W-1:0]   byte_zero,
	input logic [gwt_pkg::BYTE_W-1:0]   byte_one,
	input logic [gwt_pkg::BYTE_W-1:0]   byte_two,
	input logic [gwt_pkg::BYTE_W-1:0]   byte_three,
	input logic [gwt_pkg::USED_W-1:0]   bytes_used
);
	import gwt_pkg::*;

	// a stalled word stays valid and holds byte_one and bytes_used
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(byte_one) && $stable(bytes_used))
		else $error("texel word changed while stalled");

	a_used_legal: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> bytes_used == BYTES_SIGNED || bytes_used == BYTES_FOUR)
		else $error("bytes_used out of range");

	a_byte_three: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> byte_three == 8'd0)
		else $error("byte_three not zero");

	// the unused byte of each format stays zero
	a_unused_byte: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (bytes_used == BYTES_SIGNED && byte_two == 8'd0)
			|| (bytes_used == BYTES_FOUR && byte_zero == 8'd0))
		else $error("unused byte of format not zero");

endmodule

bind glow_wave_texel_generator gwt_checker u_gwt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.valid      (texel.valid),
	.ready      (texel.ready),
	.byte_zero  (texel.byte_zero),
	.byte_one   (texel.byte_one),
	.byte_two   (texel.byte_two),
	.byte_three (texel.byte_three),
	.bytes_used (texel.bytes_used)
);

// ===== tb/testbench.sv =====
// testbench for glow_wave_texel_generator: directed texel cases then random coordinates in both
// formats, each texel word checked against its pinned bytes or a local wave predictor; random idling on both sides
// depends on gwt_pkg, gwt_if and the glow_wave_texel_generator rtl
`timescale 1ns / 100ps

module testbench;
	import gwt_pkg::*;

	localparam int Q18_ONE         = 1 << 18;
	localparam int FRAC_ONE        = 64;
	localparam int WATCHDOG_CYCLES = 2000;
	localparam int RANDOM_PHASES   = 6;
	localparam int PHASE_WORDS     = 217;
	localparam int SETTLE_CYCLES   = 8;

	typedef struct packed {
		logic               pinned;
		gwt_format_t        fmt;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		gwt_texel_t         texel;
	} coord_case_t;

	logic clk = 1'b0;
	logic arst_n;

	gwt_coord_if coord_ch ();
	gwt_texel_if texel_ch ();
	gwt_cfg_if   cfg_ch ();

	glow_wave_texel_generator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.coord  (coord_ch),
		.texel  (texel_ch),
		.cfg    (cfg_ch)
	);

	coord_case_t directed[$];
	coord_case_t pins[$];
	gwt_texel_t  expected_texels[$];
	gwt_format_t table_fmt = FMT_SIGNED;
	gwt_format_t drive_fmt = FMT_SIGNED;
	bit          quiet = 1'b0;
	int          errors = 0;
	int          words_sent = 0;
	int          texels_checked = 0;
	int          format_writes = 0;
	int          idle_cycles = 0;
	int          stall_left = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// wave value in units of 2^-18
	function automatic int wave_q18(logic [COORD_W-1:0] c);
		int p, n, f, v;
		p = int'(c) - 32;
		if (p <= 0) begin
			n = -((-p) / FRAC_ONE) - 1;
		end else begin
			n = p / FRAC_ONE;
		end
		f = p - n * FRAC_ONE;
		v = Q18_ONE - f * f * (6 * FRAC_ONE - 4 * f);
		if (n[0]) begin
			v = -v;
		end
		return v;
	endfunction

	function automatic logic [BYTE_W-1:0] signed_byte(int v);
		int s;
		s = v / 2048;
		if (s > 127) begin
			s = 127;
		end
		if (s < -128) begin
			s = -128;
		end
		return s[BYTE_W-1:0];
	endfunction

	function automatic logic [BYTE_W-1:0] unsigned_byte(int v);
		longint num, s;
		num = longint'(v) + Q18_ONE;
		if (num < 0) begin
			return '0;
		end
		s = (num * 255) / (2 * longint'(Q18_ONE));
		if (s >= 255) begin
			return UNSIGNED_TOP;
		end
		return s[BYTE_W-1:0];
	endfunction

	function automatic gwt_texel_t predict_texel(logic [COORD_W-1:0] column,
		logic [COORD_W-1:0] row, gwt_format_t fmt);
		gwt_texel_t t;
		t.byte_three = '0;
		if (fmt == FMT_SIGNED) begin
			t.byte_zero  = signed_byte(wave_q18(column));
			t.byte_one   = signed_byte(wave_q18(row));
			t.byte_two   = '0;
			t.bytes_used = BYTES_SIGNED;
		end else begin
			t.byte_zero  = '0;
			t.byte_one   = unsigned_byte(wave_q18(row));
			t.byte_two   = unsigned_byte(wave_q18(column));
			t.bytes_used = BYTES_FOUR;
		end
		return t;
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord();
		if ($urandom_range(0, 3) != 0) begin
			return COORD_W'($urandom_range(0, 127));
		end
		case ($urandom_range(0, 7))
			0: return 7'd0;
			1: return 7'd31;
			2: return 7'd32;
			3: return 7'd33;
			4: return 7'd64;
			5: return 7'd95;
			6: return 7'd96;
			default: return 7'd127;
		endcase
	endfunction

	task automatic add_case(logic pinned, gwt_format_t fmt, logic [COORD_W-1:0] column,
		logic [COORD_W-1:0] row, logic [BYTE_W-1:0] b0, logic [BYTE_W-1:0] b1,
		logic [BYTE_W-1:0] b2, logic [BYTE_W-1:0] b3, logic [USED_W-1:0] used);
		coord_case_t c;
		c.pinned           = pinned;
		c.fmt              = fmt;
		c.column           = column;
		c.row              = row;
		c.texel.byte_zero  = b0;
		c.texel.byte_one   = b1;
		c.texel.byte_two   = b2;
		c.texel.byte_three = b3;
		c.texel.bytes_used = used;
		directed.push_back(c);
	endtask

	task automatic compare_texel(gwt_texel_t want, gwt_texel_t got);
		if (got.byte_zero !== want.byte_zero) begin
			$error("byte_zero: expected %h, got %h", want.byte_zero, got.byte_zero);
			errors++;
		end
		if (got.byte_one !== want.byte_one) begin
			$error("byte_one: expected %h, got %h", want.byte_one, got.byte_one);
			errors++;
		end
		if (got.byte_two !== want.byte_two) begin
			$error("byte_two: expected %h, got %h", want.byte_two, got.byte_two);
			errors++;
		end
		if (got.byte_three !== want.byte_three) begin
			$error("byte_three: expected %h, got %h", want.byte_three, got.byte_three);
			errors++;
		end
		if (got.bytes_used !== want.bytes_used) begin
			$error("bytes_used: expected %0d, got %0d", want.bytes_used, got.bytes_used);
			errors++;
		end
	endtask

	task automatic send_coord(coord_case_t c);
		pins.push_back(c);
		coord_ch.valid  <= 1'b1;
		coord_ch.column <= c.column;
		coord_ch.row    <= c.row;
		do @(posedge clk); while (!coord_ch.ready);
		words_sent++;
	endtask

	task automatic maybe_gap();
		if (!quiet && $urandom_range(0, 5) == 0) begin
			coord_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	task automatic await_drain();
		coord_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_texels.size() != 0);
	endtask

	task automatic write_format(gwt_format_t fmt);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= fmt;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		drive_fmt = fmt;
	endtask

	// output side back-pressure
	always @(posedge clk) begin
		if (quiet) begin
			texel_ch.ready <= 1'b1;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
		end else if ($urandom_range(0, 3) == 0) begin
			texel_ch.ready <= 1'b0;
			stall_left = $urandom_range(0, 17);
		end else begin
			texel_ch.ready <= 1'b1;
			stall_left = $urandom_range(0, 24);
		end
	end

	always @(posedge clk) begin
		gwt_texel_t want, got;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_ch.valid && cfg_ch.ready) begin
				table_fmt = gwt_format_t'(cfg_ch.data);
				format_writes++;
				moved = 1'b1;
			end
			if (coord_ch.valid && coord_ch.ready) begin
				if (pins.size() != 0 && pins[0].pinned) begin
					want = pins[0].texel;
				end else begin
					want = predict_texel(coord_ch.column, coord_ch.row, table_fmt);
				end
				if (pins.size() != 0) begin
					void'(pins.pop_front());
				end
				expected_texels.push_back(want);
				moved = 1'b1;
			end
			if (texel_ch.valid && texel_ch.ready) begin
				got.byte_zero  = texel_ch.byte_zero;
				got.byte_one   = texel_ch.byte_one;
				got.byte_two   = texel_ch.byte_two;
				got.byte_three = texel_ch.byte_three;
				got.bytes_used = texel_ch.bytes_used;
				if (expected_texels.size() == 0) begin
					$error("texel word with nothing expected: %h", got);
					errors++;
				end else begin
					compare_texel(expected_texels.pop_front(), got);
				end
				texels_checked++;
				moved = 1'b1;
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_CYCLES) begin
				$display("watchdog: no word moved for %0d cycles", WATCHDOG_CYCLES);
				$display("glow_wave_texel_generator test failed");
				$finish;
			end
		end
	end

	initial begin
		coord_case_t c;
		gwt_format_t fmt;
		arst_n          = 1'b0;
		coord_ch.valid  = 1'b0;
		coord_ch.column = '0;
		coord_ch.row    = '0;
		texel_ch.ready  = 1'b0;
		cfg_ch.valid    = 1'b0;
		cfg_ch.data     = '0;

		// signed format straight out of reset
		add_case(1, FMT_SIGNED, 7'd32, 7'd32, 8'h7f, 8'h7f, 8'h00, 8'h00, BYTES_SIGNED);
		add_case(1, FMT_SIGNED, 7'd96, 7'd96, 8'h80, 8'h80, 8'h00, 8'h00, BYTES_SIGNED);
		add_case(1, FMT_SIGNED, 7'd0, 7'd64, 8'h00, 8'h00, 8'h00, 8'h00, BYTES_SIGNED);
		add_case(1, FMT_SIGNED, 7'd96, 7'd32, 8'h80, 8'h7f, 8'h00, 8'h00, BYTES_SIGNED);
		add_case(0, FMT_SIGNED, 7'd127, 7'd127, '0, '0, '0, '0, '0);
		add_case(0, FMT_SIGNED, 7'd0, 7'd127, '0, '0, '0, '0, '0);
		add_case(0, FMT_SIGNED, 7'd127, 7'd0, '0, '0, '0, '0, '0);
		add_case(0, FMT_SIGNED, 7'd31, 7'd33, '0, '0, '0, '0, '0);
		add_case(0, FMT_SIGNED, 7'd33, 7'd31, '0, '0, '0, '0, '0);
		add_case(0, FMT_SIGNED, 7'd63, 7'd65, '0, '0, '0, '0, '0);
		add_case(0, FMT_SIGNED, 7'd95, 7'd97, '0, '0, '0, '0, '0);
		add_case(0, FMT_SIGNED, 7'd1, 7'd126, '0, '0, '0, '0, '0);
		add_case(0, FMT_SIGNED, 7'd85, 7'd42, '0, '0, '0, '0, '0);
		// four-byte format
		add_case(1, FMT_FOUR_BYTE, 7'd32, 7'd32, 8'h00, 8'h7f, 8'h7f, 8'h00, BYTES_FOUR);
		add_case(1, FMT_FOUR_BYTE, 7'd96, 7'd96, 8'h00, 8'h00, 8'h00, 8'h00, BYTES_FOUR);
		add_case(1, FMT_FOUR_BYTE, 7'd96, 7'd32, 8'h00, 8'h7f, 8'h00, 8'h00, BYTES_FOUR);
		add_case(1, FMT_FOUR_BYTE, 7'd0, 7'd64, 8'h00, 8'h7f, 8'h7f, 8'h00, BYTES_FOUR);
		add_case(0, FMT_FOUR_BYTE, 7'd127, 7'd127, '0, '0, '0, '0, '0);
		add_case(0, FMT_FOUR_BYTE, 7'd31, 7'd97, '0, '0, '0, '0, '0);
		add_case(0, FMT_FOUR_BYTE, 7'd63, 7'd65, '0, '0, '0, '0, '0);
		add_case(0, FMT_FOUR_BYTE, 7'd127, 7'd0, '0, '0, '0, '0, '0);
		add_case(0, FMT_FOUR_BYTE, 7'd42, 7'd85, '0, '0, '0, '0, '0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].fmt != drive_fmt) begin
				await_drain();
				write_format(directed[i].fmt);
			end
			maybe_gap();
			send_coord(directed[i]);
		end

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph == 0) begin
				fmt = FMT_FOUR_BYTE;
			end else if (ph == 1) begin
				fmt = FMT_SIGNED;
			end else begin
				fmt = gwt_format_t'($urandom_range(0, 1));
			end
			await_drain();
			quiet = (ph == RANDOM_PHASES - 1);
			write_format(fmt);
			repeat (PHASE_WORDS) begin
				c.pinned = 1'b0;
				c.fmt    = fmt;
				c.column = pick_coord();
				c.row    = pick_coord();
				c.texel  = '0;
				maybe_gap();
				send_coord(c);
			end
		end

		await_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_texels.size() != 0) begin
			$error("%0d texel words never arrived", expected_texels.size());
			errors++;
		end

		$display("sent %0d coordinate words over %0d format writes, checked %0d texel words",
			words_sent, format_writes, texels_checked);
		$display("both texel formats, wave extremes and random back-pressure, %0d mismatches",
			errors);
		if (errors == 0) begin
			$display("glow_wave_texel_generator test passed");
		end else begin
			$display("glow_wave_texel_generator test failed");
		end
		$finish;
	end

endmodule
